@@ src/ovr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovr_pkg
// Shared constants and helpers for the oblique volume reslicer.
// ----------------------------------------------------------------------------
package ovr_pkg;

    localparam int unsigned MAX_DIM_DEF   = 64;
    localparam int unsigned MAX_IMAGE_DEF = 1024;
    localparam int unsigned FRAC_BITS_DEF = 10;

    localparam int unsigned AXIS_W  = 21;
    localparam int unsigned NUM_AX  = 3;
    localparam int unsigned PACK_W  = NUM_AX * AXIS_W;
    localparam int unsigned SIZE_W  = 7;
    localparam int unsigned VAL_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER = 3'd0,
        REG_COL    = 3'd1,
        REG_ROW    = 3'd2,
        REG_SIZE_X = 3'd3,
        REG_SIZE_Y = 3'd4,
        REG_SIZE_Z = 3'd5
    } t_cfg_reg;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

endpackage

@@ src/oblique_volume_reslicer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oblique_volume_reslicer
// Nearest-neighbor oblique reslice of a voxel volume held in one memory.
// Write item: stored at its accept edge; one write per cycle while idle.
// Sample item: passes the multiply, sum, round, memory read and output steps
// in turn; no new item is accepted until its result is loaded for output.
// Reset (synchronous, active low) loads register defaults and clears control;
// the volume memory keeps its contents and has no clearing pass.
// ----------------------------------------------------------------------------
module oblique_volume_reslicer
    import ovr_pkg::*;
#(
    parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
    parameter int unsigned MAX_IMAGE = MAX_IMAGE_DEF,
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
    localparam int unsigned VW      = $clog2(MAX_DIM),
    localparam int unsigned CW      = $clog2(MAX_IMAGE),
    localparam int unsigned IN_W    = 3 * VW + VAL_W + 2 * CW,
    localparam int unsigned TDATA_W = ((IN_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // voxel_x, voxel_y, voxel_z, voxel_value, pixel_col, pixel_row, zero fill
    input  logic [TDATA_W-1:0]   s_axis_tdata,
    // command
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pixel_value
    output logic [VAL_W-1:0]     m_axis_tdata,
    // inside_res
    output logic                 m_axis_tuser,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PACK_W-1:0]    i_cfg_data
);

    localparam int unsigned AW     = 3 * VW;
    localparam int unsigned PROD_W = AXIS_W + CW + 1;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned RND_W  = SUM_W + 1;
    localparam logic [PACK_W-1:0] COL_RST = PACK_W'(1) << FRAC_BITS;
    localparam logic [PACK_W-1:0] ROW_RST = PACK_W'(1) << (AXIS_W + FRAC_BITS);
    localparam logic [RND_W-1:0]  HALF    = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic [RND_W-1:0]  DIM_R   = RND_W'(MAX_DIM);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_RND, S_READ, S_OUT
    } t_state;

    t_state               r_state;
    logic [PACK_W-1:0]    r_corner;
    logic [PACK_W-1:0]    r_col_step;
    logic [PACK_W-1:0]    r_row_step;
    logic [SIZE_W-1:0]    r_size [NUM_AX];
    logic [CW-1:0]        r_col;
    logic [CW-1:0]        r_row;
    logic signed [PROD_W-1:0] r_pc  [NUM_AX];
    logic signed [PROD_W-1:0] r_pr  [NUM_AX];
    logic signed [SUM_W-1:0]  r_sum [NUM_AX];
    logic [AW-1:0]        r_addr;
    logic                 r_inside;
    logic                 r_inside_d;
    logic [VAL_W-1:0]     r_rd_data;
    logic                 r_m_valid;
    logic [VAL_W-1:0]     r_m_data;
    logic                 r_m_inside;
    logic [VAL_W-1:0]     r_mem [0:(2**AW)-1];

    logic [VW-1:0]        w_vx, w_vy, w_vz;
    logic [VAL_W-1:0]     w_vval;
    logic                 w_in_acc;
    logic                 w_wr_en;
    logic                 w_out_load;
    logic signed [PROD_W-1:0] n_pc  [NUM_AX];
    logic signed [PROD_W-1:0] n_pr  [NUM_AX];
    logic signed [SUM_W-1:0]  n_sum [NUM_AX];
    logic [RND_W-1:0]     w_rnd [NUM_AX];
    logic [NUM_AX-1:0]    w_in_ax;
    logic [AW-1:0]        n_addr;

    assign w_vx   = s_axis_tdata[0 +: VW];
    assign w_vy   = s_axis_tdata[VW +: VW];
    assign w_vz   = s_axis_tdata[2*VW +: VW];
    assign w_vval = s_axis_tdata[3*VW +: VAL_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_wr_en       = w_in_acc && (s_axis_tuser == CMD_WRITE)
                           && (RND_W'(w_vx) < DIM_R) && (RND_W'(w_vy) < DIM_R)
                           && (RND_W'(w_vz) < DIM_R);
    assign w_out_load    = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_inside;

    always_comb begin
        logic signed [SUM_W-1:0] v_mag;
        logic [RND_W-1:0]        v_lim;
        for (int a = 0; a < NUM_AX; a++) begin
            n_pc[a] = $signed({1'b0, r_col}) * $signed(r_col_step[a*AXIS_W +: AXIS_W]);
            n_pr[a] = $signed({1'b0, r_row}) * $signed(r_row_step[a*AXIS_W +: AXIS_W]);
            n_sum[a] = $signed(r_corner[a*AXIS_W +: AXIS_W]) + r_pc[a] + r_pr[a];
        end
        for (int a = 0; a < NUM_AX; a++) begin
            v_mag    = r_sum[a][SUM_W-1] ? -r_sum[a] : r_sum[a];
            w_rnd[a] = ({1'b0, v_mag} + HALF) >> FRAC_BITS;
            v_lim    = (RND_W'(r_size[a]) > DIM_R) ? DIM_R : RND_W'(r_size[a]);
            w_in_ax[a] = (!r_sum[a][SUM_W-1] || (w_rnd[a] == '0)) && (w_rnd[a] < v_lim);
        end
        n_addr = {w_rnd[2][VW-1:0], w_rnd[1][VW-1:0], w_rnd[0][VW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner   <= '0;
            r_col_step <= COL_RST;
            r_row_step <= ROW_RST;
            for (int a = 0; a < NUM_AX; a++) begin
                r_size[a] <= SIZE_W'(64);
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CORNER: r_corner   <= i_cfg_data;
                REG_COL:    r_col_step <= i_cfg_data;
                REG_ROW:    r_row_step <= i_cfg_data;
                REG_SIZE_X: r_size[0]  <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y: r_size[1]  <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z: r_size[2]  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[{w_vz, w_vy, w_vx}] <= w_vval;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (m_axis_tready && !w_out_load) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (s_axis_tuser == CMD_SAMPLE)) begin
                        r_col   <= s_axis_tdata[3*VW+VAL_W +: CW];
                        r_row   <= s_axis_tdata[3*VW+VAL_W+CW +: CW];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pc    <= n_pc;
                    r_pr    <= n_pr;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= n_sum;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_addr   <= n_addr;
                    r_inside <= &w_in_ax;
                    r_state  <= S_READ;
                end
                S_READ: begin
                    r_inside_d <= r_inside;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_m_valid  <= 1'b1;
                        r_m_data   <= r_inside_d ? r_rd_data : '0;
                        r_m_inside <= r_inside_d;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
